// ===== sv/sse_pkg.sv =====
// ---------------------------------------------------------------------------
// sse_pkg
// Shared types and constants of the scored segment evictor.
// ---------------------------------------------------------------------------
package sse_pkg;

	localparam int SEGMENTS_DEF = 32;
	localparam int MAX_RESULTS  = 32;

	localparam logic [31:0] MAX_TOKENS_RST = 32'd4096;
	localparam logic [15:0] THRESH_RST     = 16'd58982;

	localparam logic signed [15:0] SCORE_ONE  = 16'sd16384;
	localparam logic signed [15:0] SCORE_HALF = 16'sd8192;

	// Operation codes carried in the mode field.
	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_BOOST = 2'd1;
	localparam logic [1:0] MODE_PRUNE = 2'd2;
	localparam logic [1:0] MODE_CLEAR = 2'd3;

	// Status codes of a result.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	// Configuration register indexes.
	localparam logic REG_MAX_TOKENS = 1'b0;
	localparam logic REG_THRESHOLD  = 1'b1;

	// One table entry as stored in memory.
	typedef struct packed {
		logic [31:0]        key;
		logic [23:0]        tokens;
		logic signed [15:0] score;
		logic               pinned;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== sv/sse_ram.sv =====
// ---------------------------------------------------------------------------
// sse_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module sse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/scored_segment_evictor_core.sv =====
// ---------------------------------------------------------------------------
// scored_segment_evictor_core
// Ordered segment table with add, boost, prune and clear operations.
// ---------------------------------------------------------------------------
// Usage: requests enter on s_axis (mode, key, tokens, pinned, delta, limit).
// Each request gives one or more results on m_axis; tlast marks the final
// result of a request. The table lives in one RAM with registered read.
// Add and clear raise their result from the output state S_OUT. Boost
// scans the table, one entry a cycle. Prune compares the token sum with
// its target through the registered product of the two configuration
// registers; each removal scans all n entries for the minimum and closes
// the gap by copying each later entry down one place through the states
// S_CRD and S_CWR. The result of a removal is held back until the next
// check or scan shows whether another removal follows.
// One request is worked on at a time; s_axis_tready is low while busy.
// A result waits in the output register while m_axis_tready is low and the
// sequencer stalls at the end of the next removal until it is taken. Reset
// empties the table at once (entry count and token sum cleared, no memory
// sweep) and restores the configuration registers to 4096 and 58982.
// ---------------------------------------------------------------------------
module scored_segment_evictor_core #(
	parameter int SEGMENTS = sse_pkg::SEGMENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mode[1:0], segment_key[33:2], seg_tokens[57:34], pinned[58],
	// score_delta[74:59], max_evict[80:75], zero fill to 88 bits
	input  logic [87:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[1:0], evicted_valid[2], evicted_key[34:3], evicted_total[40:35],
	// table_tokens[69:41], needs_eviction[70], zero fill to 72 bits
	output logic [71:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	localparam int AW = $clog2(SEGMENTS);
	localparam int CW = $clog2(SEGMENTS + 1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_BSCAN = 8'b00000010,
		S_PCHK  = 8'b00000100,
		S_MSCAN = 8'b00001000,
		S_CRD   = 8'b00010000,
		S_CWR   = 8'b00100000,
		S_BWR   = 8'b01000000,
		S_OUT   = 8'b10000000
	} state_t;

	state_t state_q;

	logic [31:0] max_tokens_q;
	logic [15:0] thresh_q;
	logic [CW-1:0] count_q;
	logic [28:0] sum_q;

	// Request fields held for the whole operation.
	logic [31:0]        key_q;
	logic signed [15:0] delta_q;
	logic [5:0]         limit_q;

	// Scan, compaction and result state.
	logic [CW-1:0] idx_q;
	logic [CW-1:0] ridx_q;
	logic          found_q;
	logic [AW-1:0] best_q;
	logic signed [15:0] bscore_q;
	sse_pkg::entry_t best_e_q;
	logic [5:0] n_q;
	logic [47:0] rhs_q;

	// RAM ports.
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	sse_pkg::entry_t      ram_wdata;
	logic [AW-1:0]        ram_raddr;
	sse_pkg::entry_t      ram_rdata;

	sse_ram #(.WIDTH(sse_pkg::ENTRY_W), .DEPTH(SEGMENTS)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	logic s_acc, m_busy;
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign m_busy = m_axis_tvalid && !m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && !m_axis_tvalid;

	// Threshold product of the two configuration registers, registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rhs_q <= 48'd0;
		end else begin
			rhs_q <= {16'd0, max_tokens_q} * {32'd0, thresh_q};
		end
	end

	logic need_now;
	logic [28:0] sum_next;
	assign need_now = ({3'd0, sum_q, 16'd0} >= rhs_q);

	// The sum lies above floor(p/81920) exactly when sum*81920 exceeds p,
	// and 81920 is five times 2^14.
	logic [31:0] sum_x5;
	logic        tgt_over;
	assign sum_x5   = {1'b0, sum_q, 2'b00} + {3'd0, sum_q};
	assign tgt_over = ({2'd0, sum_x5, 14'd0} > rhs_q);

	// Boost saturation.
	logic signed [16:0] bsum;
	logic signed [15:0] bsat;
	always_comb begin
		bsum = {ram_rdata.score[15], ram_rdata.score} + {delta_q[15], delta_q};
		if (bsum > 17'sd16384) begin
			bsat = sse_pkg::SCORE_ONE;
		end else if (bsum < -17'sd32768) begin
			bsat = -16'sd32768;
		end else begin
			bsat = bsum[15:0];
		end
	end

	logic rd_ok;
	assign rd_ok = (ridx_q < count_q);

	// Read address follows the scan pointer; a scan starts from entry zero.
	assign ram_raddr = ((state_q == S_IDLE) || (state_q == S_PCHK)) ? '0
		: idx_q[AW-1:0];

	// Write port steering.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = ram_rdata;
		case (state_q)
			S_IDLE: begin
				ram_we    = s_acc && (s_axis_tdata[1:0] == sse_pkg::MODE_ADD)
					&& (count_q < CW'(SEGMENTS));
				ram_waddr = count_q[AW-1:0];
				ram_wdata.key    = s_axis_tdata[33:2];
				ram_wdata.tokens = s_axis_tdata[57:34];
				ram_wdata.pinned = s_axis_tdata[58];
				ram_wdata.score  = s_axis_tdata[58] ? sse_pkg::SCORE_ONE
					: sse_pkg::SCORE_HALF;
			end
			S_BSCAN: begin
				ram_we          = rd_ok && (ram_rdata.key == key_q);
				ram_waddr       = ridx_q[AW-1:0];
				ram_wdata.score = bsat;
			end
			S_CWR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(ridx_q - CW'(1));
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign sum_next = sum_q;

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			max_tokens_q  <= sse_pkg::MAX_TOKENS_RST;
			thresh_q      <= sse_pkg::THRESH_RST;
			count_q       <= '0;
			sum_q         <= '0;
			m_axis_tvalid <= 1'b0;
			idx_q         <= '0;
			ridx_q        <= '0;
			found_q       <= 1'b0;
			n_q           <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == sse_pkg::REG_MAX_TOKENS) begin
					max_tokens_q <= cfg_wdata;
				end else begin
					thresh_q <= cfg_wdata[15:0];
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						key_q   <= s_axis_tdata[33:2];
						delta_q <= s_axis_tdata[74:59];
						limit_q <= (s_axis_tdata[80:75] > 6'd32) ? 6'd32
							: s_axis_tdata[80:75];
						idx_q   <= '0;
						ridx_q  <= '0;
						n_q     <= '0;
						m_axis_tdata[40:2] <= '0;
						m_axis_tdata[1:0]  <= sse_pkg::ST_OK;
						m_axis_tlast       <= 1'b1;
						case (s_axis_tdata[1:0])
							sse_pkg::MODE_ADD: begin
								if (count_q < CW'(SEGMENTS)) begin
									count_q <= count_q + CW'(1);
									sum_q   <= sum_q + {5'd0, s_axis_tdata[57:34]};
								end else begin
									m_axis_tdata[1:0] <= sse_pkg::ST_FULL;
								end
								state_q <= S_OUT;
							end
							sse_pkg::MODE_BOOST: begin
								idx_q   <= CW'(1);
								state_q <= S_BSCAN;
							end
							sse_pkg::MODE_PRUNE: begin
								state_q <= S_PCHK;
							end
							default: begin
								count_q <= '0;
								sum_q   <= '0;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_BSCAN: begin
					// rdata holds entry ridx_q; a match is written back here.
					if (!rd_ok) begin
						m_axis_tdata[1:0] <= sse_pkg::ST_NOTFOUND;
						state_q <= S_OUT;
					end else if (ram_rdata.key == key_q) begin
						state_q <= S_BWR;
					end else begin
						ridx_q <= ridx_q + CW'(1);
						idx_q  <= idx_q + CW'(1);
					end
				end
				S_BWR: begin
					state_q <= S_OUT;
				end
				S_PCHK: begin
					// Another removal, or the end of the prune.
					if (tgt_over && (n_q < limit_q)) begin
						idx_q   <= CW'(1);
						ridx_q  <= '0;
						found_q <= 1'b0;
						state_q <= S_MSCAN;
					end else if (n_q == 6'd0) begin
						state_q <= S_OUT;
					end else begin
						m_axis_tvalid <= 1'b1;
						m_axis_tlast  <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				S_MSCAN: begin
					if (rd_ok) begin
						if (!ram_rdata.pinned && (!found_q || ram_rdata.score < bscore_q))
						begin
							found_q  <= 1'b1;
							best_q   <= ridx_q[AW-1:0];
							bscore_q <= ram_rdata.score;
							best_e_q <= ram_rdata;
						end
						ridx_q <= ridx_q + CW'(1);
						idx_q  <= idx_q + CW'(1);
					end else if (!found_q) begin
						if (n_q == 6'd0) begin
							state_q <= S_OUT;
						end else begin
							m_axis_tvalid <= 1'b1;
							m_axis_tlast  <= 1'b1;
							state_q       <= S_IDLE;
						end
					end else begin
						// A further removal follows, so the held result is not the last.
						if (n_q != 6'd0) begin
							m_axis_tvalid <= 1'b1;
							m_axis_tlast  <= 1'b0;
						end
						sum_q  <= sum_q - {5'd0, best_e_q.tokens};
						idx_q  <= {1'b0, best_q} + CW'(1);
						ridx_q <= {1'b0, best_q} + CW'(1);
						state_q <= S_CRD;
					end
				end
				S_CRD: begin
					// Wait for read of ridx_q, then copy down.
					if (ridx_q < count_q) begin
						state_q <= S_CWR;
					end else if (!m_busy) begin
						count_q <= count_q - CW'(1);
						n_q     <= n_q + 6'd1;
						m_axis_tdata[1:0]  <= sse_pkg::ST_OK;
						m_axis_tdata[2]    <= 1'b1;
						m_axis_tdata[34:3] <= best_e_q.key;
						m_axis_tdata[40:35] <= n_q + 6'd1;
						m_axis_tdata[69:41] <= sum_q;
						m_axis_tdata[70]    <= need_now;
						m_axis_tdata[71]    <= 1'b0;
						state_q <= S_PCHK;
					end
				end
				S_CWR: begin
					ridx_q  <= ridx_q + CW'(1);
					idx_q   <= idx_q + CW'(1);
					state_q <= S_CRD;
				end
				S_OUT: begin
					m_axis_tvalid       <= 1'b1;
					m_axis_tdata[69:41] <= sum_next;
					m_axis_tdata[70]    <= need_now;
					m_axis_tdata[71]    <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/sse_checker.sv =====
// ---------------------------------------------------------------------------
// sse_checker
// Port-level checks of the scored segment evictor.
// ---------------------------------------------------------------------------
module sse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// No request is taken while a result is on offer.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("request accepted with result pending");

	// A result that names no removal ends its request.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tlast)
		else $error("non-eviction result without last");

	// A result naming a removal is never an error.
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == sse_pkg::ST_OK)
		else $error("eviction with error status");

endmodule

bind scored_segment_evictor_core sse_checker u_sse_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);

// ===== bench/tb_scored_segment_evictor_core.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_scored_segment_evictor_core
// Self-checking bench for the segment table: add, boost, prune and clear
// requests go in with bursty timing, and every result is checked against
// a behavioural copy of the table while the output side stalls at random.
// ---------------------------------------------------------------------------

// Expected content of one result transaction.
typedef struct {
	logic [1:0]  status;
	logic        ev_valid;
	logic [31:0] ev_key;
	logic [5:0]  ev_total;
	logic [28:0] tokens;
	logic        needs;
	logic        last;
} seg_result_t;

// Behavioural table, with a queue of results still owed by the block.
class segment_scoreboard;
	logic [31:0]        tab_key[sse_pkg::SEGMENTS_DEF];
	logic [23:0]        tab_tokens[sse_pkg::SEGMENTS_DEF];
	int                 tab_score[sse_pkg::SEGMENTS_DEF];
	logic               tab_pinned[sse_pkg::SEGMENTS_DEF];
	int                 used;
	logic [28:0]        token_total;
	logic [31:0]        capacity;
	logic [15:0]        thresh;
	seg_result_t        owed[$];
	int                 errors;
	int                 results_seen;
	int                 evictions_seen;

	function void clear_state();
		used = 0;
		token_total = '0;
		capacity = sse_pkg::MAX_TOKENS_RST;
		thresh = sse_pkg::THRESH_RST;
		errors = 0;
	endfunction

	function void set_reg(logic idx, logic [31:0] val);
		if (idx == sse_pkg::REG_MAX_TOKENS)
			capacity = val;
		else
			thresh = val[15:0];
	endfunction

	// Pushes one expected result built from the current table state.
	function void owe(logic [1:0] st, logic v, logic [31:0] k, int n, logic l);
		seg_result_t r;
		longint unsigned lhs, rhs;
		lhs = longint'(token_total) * 65536;
		rhs = longint'(thresh) * longint'(capacity);
		r.status = st;
		r.ev_valid = v;
		r.ev_key = k;
		r.ev_total = n[5:0];
		r.tokens = token_total;
		r.needs = (lhs >= rhs);
		r.last = l;
		owed.push_back(r);
	endfunction

	// Applies one accepted request to the table and notes its results.
	function void note_request(logic [1:0] mode, logic [31:0] key, logic [23:0] tok,
	                           logic pin, logic signed [15:0] delta, logic [5:0] lim);
		longint unsigned goal;
		int n, cap, best, s;
		logic [31:0] k;
		bit hit;
		case (mode)
			sse_pkg::MODE_ADD: begin
				if (used >= sse_pkg::SEGMENTS_DEF) begin
					owe(sse_pkg::ST_FULL, 0, 0, 0, 1);
				end else begin
					tab_key[used] = key;
					tab_tokens[used] = tok;
					tab_score[used] = pin ? sse_pkg::SCORE_ONE : sse_pkg::SCORE_HALF;
					tab_pinned[used] = pin;
					used++;
					token_total = token_total + tok;
					owe(sse_pkg::ST_OK, 0, 0, 0, 1);
				end
			end
			sse_pkg::MODE_BOOST: begin
				hit = 0;
				for (int i = 0; i < used && !hit; i++) begin
					if (tab_key[i] == key) begin
						s = tab_score[i] + int'(delta);
						if (s > sse_pkg::SCORE_ONE) s = sse_pkg::SCORE_ONE;
						if (s < -32768) s = -32768;
						tab_score[i] = s;
						hit = 1;
					end
				end
				owe(hit ? sse_pkg::ST_OK : sse_pkg::ST_NOTFOUND, 0, 0, 0, 1);
			end
			sse_pkg::MODE_PRUNE: begin
				goal = (longint'(thresh) * longint'(capacity) * 4) / 327680;
				cap = (lim > sse_pkg::MAX_RESULTS) ? sse_pkg::MAX_RESULTS : lim;
				n = 0;
				while (longint'(token_total) > goal && n < cap) begin
					best = -1;
					for (int i = 0; i < used; i++)
						if (!tab_pinned[i] && (best < 0 || tab_score[i] < tab_score[best]))
							best = i;
					if (best < 0) break;
					k = tab_key[best];
					token_total = token_total - tab_tokens[best];
					for (int i = best; i + 1 < used; i++) begin
						tab_key[i] = tab_key[i + 1];
						tab_tokens[i] = tab_tokens[i + 1];
						tab_score[i] = tab_score[i + 1];
						tab_pinned[i] = tab_pinned[i + 1];
					end
					used--;
					n++;
					owe(sse_pkg::ST_OK, 1, k, n, 0);
				end
				if (n == 0)
					owe(sse_pkg::ST_OK, 0, 0, 0, 1);
				else
					owed[$].last = 1;
			end
			default: begin
				used = 0;
				token_total = '0;
				owe(sse_pkg::ST_OK, 0, 0, 0, 1);
			end
		endcase
	endfunction

	// Compares one result transaction with the oldest expectation.
	function void check_result(logic [71:0] d, logic l);
		seg_result_t e;
		results_seen++;
		if (d[2]) evictions_seen++;
		if (owed.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("ERROR: unexpected result tdata=%h tlast=%b", d, l);
			return;
		end
		e = owed.pop_front();
		if (d[1:0] !== e.status || d[2] !== e.ev_valid || d[34:3] !== e.ev_key ||
		    d[40:35] !== e.ev_total || d[69:41] !== e.tokens || d[70] !== e.needs ||
		    d[71] !== 1'b0 || l !== e.last) begin
			errors++;
			if (errors <= 10) begin
				$display("ERROR: got st=%0d ev=%b key=%h n=%0d tok=%0d ne=%b last=%b",
				         d[1:0], d[2], d[34:3], d[40:35], d[69:41], d[70], l);
				$display("       exp st=%0d ev=%b key=%h n=%0d tok=%0d ne=%b last=%b",
				         e.status, e.ev_valid, e.ev_key, e.ev_total, e.tokens,
				         e.needs, e.last);
			end
		end
	endfunction
endclass

module tb_scored_segment_evictor_core;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic        m_axis_tlast;

	segment_scoreboard table_sb;
	int          burst_left;
	int          requests_sent;
	int          mode_count[4];
	int          stall_phase;
	longint      cycles;

	scored_segment_evictor_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	// 20 ns clock.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			table_sb.check_result(m_axis_tdata, m_axis_tlast);
	end

	// Receiver stall pattern: free-running stretches alternate with random stalls.
	always @(negedge clk) begin
		stall_phase <= (stall_phase + 1) % 160;
		if (stall_phase < 50)
			m_axis_tready <= 1'b1;
		else if (stall_phase < 110)
			m_axis_tready <= ($urandom_range(0, 3) != 0);
		else
			m_axis_tready <= ($urandom_range(0, 2) == 0);
	end

	// Sends one request, entered and left at a falling edge.
	task automatic send_req(logic [1:0] mode, logic [31:0] key, logic [23:0] tok,
	                        logic pin, logic signed [15:0] delta, logic [5:0] lim);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 10);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'b0, lim, delta, pin, tok, key, mode};
		do @(posedge clk); while (!s_axis_tready);
		table_sb.note_request(mode, key, tok, pin, delta, lim);
		requests_sent++;
		mode_count[mode]++;
		burst_left--;
		@(negedge clk);
	endtask

	// Holds the sender off until every owed result has been taken.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (table_sb.owed.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		table_sb.set_reg(idx, val);
	endtask

	// Picks a key that is mostly present in the table.
	function automatic logic [31:0] pick_key();
		if (table_sb.used > 0 && $urandom_range(0, 5) != 0)
			return table_sb.tab_key[$urandom_range(0, table_sb.used - 1)];
		return $urandom();
	endfunction

	function automatic logic [23:0] pick_tokens();
		if ($urandom_range(0, 9) == 0)
			return 24'($urandom());
		return 24'($urandom_range(0, 1500));
	endfunction

	function automatic logic signed [15:0] pick_delta();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($urandom());
			default: return 16'($urandom_range(0, 8000) - 4000);
		endcase
	endfunction

	initial begin
		int fills;
		logic [31:0] caps[6];
		logic [15:0] ths[6];

		caps = '{32'd4096, 32'hFFFFFFFF, 32'd1, 32'd0, 32'd20000, 32'd9000};
		ths = '{16'd58982, 16'hFFFF, 16'd0, 16'd0, 16'd32768, 16'd40000};
		table_sb = new();
		table_sb.clear_state();
		cycles = 0;
		stall_phase = 0;
		burst_left = 0;
		requests_sent = 0;
		mode_count = '{0, 0, 0, 0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: field extremes, saturation both ways, a miss, prunes and a clear.
		send_req(sse_pkg::MODE_ADD, 32'h0, 24'hFFFFFF, 1'b0, 16'sd0, 6'd0);
		send_req(sse_pkg::MODE_ADD, 32'hFFFFFFFF, 24'd0, 1'b1, 16'sd0, 6'd63);
		send_req(sse_pkg::MODE_ADD, 32'hA5A5A5A5, 24'd100, 1'b0, 16'sd0, 6'd0);
		send_req(sse_pkg::MODE_ADD, 32'h5A5A5A5A, 24'd200, 1'b0, 16'sd0, 6'd0);
		send_req(sse_pkg::MODE_BOOST, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1, 16'sh7FFF, 6'd63);
		send_req(sse_pkg::MODE_BOOST, 32'hA5A5A5A5, 24'd0, 1'b0, 16'sh7FFF, 6'd0);
		send_req(sse_pkg::MODE_BOOST, 32'h5A5A5A5A, 24'd0, 1'b0, 16'sh8000, 6'd0);
		send_req(sse_pkg::MODE_BOOST, 32'h5A5A5A5A, 24'd0, 1'b0, 16'sh8000, 6'd0);
		send_req(sse_pkg::MODE_BOOST, 32'h12345678, 24'd0, 1'b0, 16'sd5, 6'd0);
		send_req(sse_pkg::MODE_PRUNE, 32'h0, 24'd0, 1'b0, 16'sd0, 6'd0);
		send_req(sse_pkg::MODE_PRUNE, 32'h0, 24'd0, 1'b0, 16'sd0, 6'd1);
		send_req(sse_pkg::MODE_PRUNE, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1, 16'shFFFF, 6'd63);
		send_req(sse_pkg::MODE_PRUNE, 32'h0, 24'd0, 1'b0, 16'sd0, 6'd32);
		send_req(sse_pkg::MODE_ADD, 32'h0, 24'd5, 1'b0, 16'sd0, 6'd0);
		send_req(sse_pkg::MODE_ADD, 32'h0, 24'd7, 1'b0, 16'sd0, 6'd0);
		send_req(sse_pkg::MODE_BOOST, 32'h0, 24'd0, 1'b0, 16'sd100, 6'd0);
		send_req(sse_pkg::MODE_CLEAR, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1, 16'shFFFF, 6'd63);
		send_req(sse_pkg::MODE_PRUNE, 32'h0, 24'd0, 1'b0, 16'sd0, 6'd5);
		drain();

		// Random phases: a setting every third phase, then at times a clear, a fill, boosts, a prune and some noise.
		for (int ph = 0; requests_sent < 300; ph++) begin
			if (ph % 3 == 0) begin
				drain();
				if (ph / 3 < 6) begin
					write_reg(sse_pkg::REG_MAX_TOKENS, caps[ph / 3]);
					write_reg(sse_pkg::REG_THRESHOLD, {16'b0, ths[ph / 3]});
				end else begin
					write_reg(sse_pkg::REG_MAX_TOKENS, $urandom_range(1, 60000));
					write_reg(sse_pkg::REG_THRESHOLD, $urandom());
				end
			end
			if ($urandom_range(0, 2) == 0)
				send_req(sse_pkg::MODE_CLEAR, $urandom(), 24'($urandom()), 1'($urandom()),
				         16'($urandom()), 6'($urandom()));
			fills = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 12);
			for (int i = 0; i < fills; i++)
				send_req(sse_pkg::MODE_ADD, ($urandom_range(0, 3) == 0) ? pick_key() : $urandom(),
				         pick_tokens(), ($urandom_range(0, 3) == 0), 16'($urandom()),
				         6'($urandom()));
			repeat ($urandom_range(1, 6))
				send_req(sse_pkg::MODE_BOOST, pick_key(), 24'($urandom()), 1'($urandom()),
				         pick_delta(), 6'($urandom()));
			send_req(sse_pkg::MODE_PRUNE, $urandom(), 24'($urandom()), 1'($urandom()),
			         16'($urandom()),
			         6'(($urandom_range(0, 4) == 0) ? $urandom_range(33, 63)
			                                        : $urandom_range(0, 8)));
			if ($urandom_range(0, 3) == 0)
				send_req(2'($urandom()), pick_key(), pick_tokens(), 1'($urandom()),
				         pick_delta(), 6'($urandom_range(0, 63)));
		end
		drain();
		write_reg(sse_pkg::REG_MAX_TOKENS, sse_pkg::MAX_TOKENS_RST);
		write_reg(sse_pkg::REG_THRESHOLD, {16'b0, sse_pkg::THRESH_RST});

		$display("Run: %0d requests (add %0d, boost %0d, prune %0d, clear %0d),",
		         requests_sent, mode_count[sse_pkg::MODE_ADD],
		         mode_count[sse_pkg::MODE_BOOST], mode_count[sse_pkg::MODE_PRUNE],
		         mode_count[sse_pkg::MODE_CLEAR]);
		$display("     %0d results checked, %0d of them evictions.",
		         table_sb.results_seen, table_sb.evictions_seen);
		if (table_sb.errors == 0 && table_sb.owed.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/sse_pkg.sv
sv/sse_ram.sv
sv/scored_segment_evictor_core.sv
sv/sse_checker.sv
bench/tb_scored_segment_evictor_core.sv
